FILE: hw/rtl/tgql_pkg.sv
// Package for the glyph quad layout core: sizes, character codes, glyph entry
// type, controller commands and status, saturation helper. No dependencies.
package tgql_pkg;

   localparam int GLYPH_ENTRIES = 256;
   localparam int GLYPH_IDX_BITS = $clog2(GLYPH_ENTRIES);
   localparam int COORD_BITS = 16;
   localparam int SUM_BITS = COORD_BITS + 2;
   localparam int TW_BITS = 13;
   localparam int DIV_STEPS = COORD_BITS - 1;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_TAB = 8'd9;
   localparam logic [7:0] CH_CARET = 8'd94;
   localparam logic [7:0] CH_ZERO = 8'd48;
   localparam logic [7:0] CH_SEVEN = 8'd55;
   localparam logic [7:0] CH_SPACE = 8'd32;

   localparam logic [1:0] CSR_LINE_HEIGHT = 2'd0;
   localparam logic [1:0] CSR_DESCENDER = 2'd1;
   localparam logic [1:0] CSR_TAB_COUNT = 2'd2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_LAYOUT = 1'b1;

   typedef struct packed {
      logic [7:0] adv;
      logic signed [7:0] offx;
      logic signed [7:0] base;
      logic [7:0] w;
      logic [7:0] h;
      logic [11:0] tl;
      logic [11:0] tt;
      logic [11:0] tr;
      logic [11:0] tb;
   } glyph_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x0;
      logic signed [COORD_BITS-1:0] y0;
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
      logic [11:0] u0;
      logic [11:0] v0;
      logic [11:0] u1;
      logic [11:0] v1;
      logic [2:0] color;
      logic is_glyph;
      logic [15:0] lines;
      logic end_mark;
   } result_type;

   typedef enum logic [1:0] {RD_ITEM, RD_CARET, RD_SPACE} rd_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_CARET_EMIT, ST_CHAR, ST_GLYPH_EMIT,
      ST_TAB_MUL, ST_TAB_DIV, ST_TAB_APPLY, ST_FINISH
   } state_type;

   typedef struct packed {
      logic write;
      logic load;
      logic start;
      logic rd_en;
      rd_sel_type rd_sel;
      logic set_color;
      logic newline;
      logic emit_quad;
      logic emit_sum;
      logic tab_init;
      logic tab_step;
      logic tab_apply;
   } cmd_type;

   typedef struct packed {
      logic is_digit;
      logic is_newline;
      logic is_tab;
      logic is_caret;
      logic last;
      logic tw_zero;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
         input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] hi;
      logic signed [SUM_BITS-1:0] lo;
      hi = SUM_BITS'((1 << (COORD_BITS - 1)) - 1);
      lo = -hi - SUM_BITS'(1);
      if (v > hi) return hi[COORD_BITS-1:0];
      else if (v < lo) return lo[COORD_BITS-1:0];
      else return v[COORD_BITS-1:0];
   endfunction

endpackage

FILE: hw/rtl/tgql_datapath.sv
// Datapath of the glyph quad layout core: glyph table memory, pen state,
// configuration registers, tab divider and result register. Uses tgql_pkg.
module tgql_datapath (
   input  logic clock,
   input  logic reset,
   input  tgql_pkg::cmd_type cmd,
   output tgql_pkg::status_type status,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,
   input  logic [7:0] req_char_code,
   input  logic req_last,
   input  tgql_pkg::glyph_type req_glyph,
   output logic rsp_valid,
   input  logic rsp_ready,
   output tgql_pkg::result_type rsp_data
);
   import tgql_pkg::*;

   glyph_type mem [GLYPH_ENTRIES];
   glyph_type rd_data_ff;
   logic rd_hit_ff;
   glyph_type glyph;

   logic [7:0] line_height_ff;
   logic signed [7:0] descender_ff;
   logic [4:0] tab_count_ff;

   logic [7:0] code_ff;
   logic last_ff;

   logic signed [COORD_BITS-1:0] pen_x_ff, pen_x_in;
   logic signed [COORD_BITS-1:0] pen_y_ff, pen_y_in;
   logic [2:0] color_ff, color_in;
   logic [15:0] lines_ff, lines_in;

   logic [TW_BITS-1:0] tw_ff;
   logic [TW_BITS-1:0] rem_ff, rem_in;
   logic [COORD_BITS-2:0] dvd_ff, dvd_in;
   logic [COORD_BITS-2:0] px_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;

   logic rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   logic [7:0] rd_addr;
   logic [7:0] color_diff;
   logic [TW_BITS:0] trial;
   logic signed [SUM_BITS-1:0] x0_sum, y0_sum, x1_sum, y1_sum, adv_sum, tab_sum, nl_sum;
   logic signed [COORD_BITS-1:0] x0, y0;

   // glyph table
   always_ff @(posedge clock) begin
      if (cmd.write && (int'(req_char_code) < GLYPH_ENTRIES)) begin
         mem[req_char_code[GLYPH_IDX_BITS-1:0]] <= req_glyph;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr[GLYPH_IDX_BITS-1:0]];
         rd_hit_ff <= int'(rd_addr) < GLYPH_ENTRIES;
      end
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_CARET: rd_addr = CH_CARET;
         RD_SPACE: rd_addr = CH_SPACE;
         default:  rd_addr = code_ff;
      endcase
   end

   assign glyph = rd_hit_ff ? rd_data_ff : '0;

   // configuration and item registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_height_ff <= 8'd16;
         descender_ff <= -8'sd4;
         tab_count_ff <= 5'd4;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LINE_HEIGHT: line_height_ff <= csr_data;
            CSR_DESCENDER:   descender_ff <= csr_data;
            CSR_TAB_COUNT:   tab_count_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code_ff <= req_char_code;
         last_ff <= req_last;
      end
   end

   // arithmetic
   assign x0_sum = SUM_BITS'(pen_x_ff) + SUM_BITS'(glyph.offx);
   assign y0_sum = SUM_BITS'(pen_y_ff) + SUM_BITS'({1'b0, line_height_ff})
                   - SUM_BITS'(glyph.base);
   assign x0 = sat_coord(x0_sum);
   assign y0 = sat_coord(y0_sum);
   assign x1_sum = SUM_BITS'(x0) + SUM_BITS'({1'b0, glyph.w});
   assign y1_sum = SUM_BITS'(y0) + SUM_BITS'({1'b0, glyph.h});
   assign adv_sum = SUM_BITS'(pen_x_ff) + SUM_BITS'({1'b0, glyph.adv});
   assign nl_sum = SUM_BITS'(pen_y_ff) + SUM_BITS'({1'b0, line_height_ff});
   assign tab_sum = SUM_BITS'({1'b0, px_ff}) - SUM_BITS'({1'b0, rem_ff})
                    + SUM_BITS'({1'b0, tw_ff});
   assign trial = {rem_ff, dvd_ff[COORD_BITS-2]};
   assign color_diff = code_ff - CH_ZERO;

   always_comb begin
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      color_in = color_ff;
      lines_in = lines_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      if (cmd.start) begin
         pen_x_in = '0;
         pen_y_in = sat_coord(-SUM_BITS'(descender_ff));
         color_in = 3'd7;
         lines_in = 16'd1;
      end
      if (cmd.set_color) color_in = color_diff[2:0];
      if (cmd.newline) begin
         pen_x_in = '0;
         pen_y_in = sat_coord(nl_sum);
         if (lines_ff != 16'hFFFF) lines_in = lines_ff + 16'd1;
      end
      if (cmd.tab_init) begin
         rem_in = '0;
         dvd_in = pen_x_ff[COORD_BITS-1] ? '0 : pen_x_ff[COORD_BITS-2:0];
         cnt_in = '0;
      end
      if (cmd.tab_step) begin
         rem_in = (trial >= {1'b0, tw_ff}) ? TW_BITS'(trial - {1'b0, tw_ff})
                                           : trial[TW_BITS-1:0];
         dvd_in = {dvd_ff[COORD_BITS-3:0], 1'b0};
         cnt_in = cnt_ff + DIV_CNT_BITS'(1);
      end
      if (cmd.tab_apply) pen_x_in = sat_coord(tab_sum);
      if (cmd.emit_quad) begin
         rsp_valid_in = 1'b1;
         rsp_in.x0 = x0;
         rsp_in.y0 = y0;
         rsp_in.x1 = sat_coord(x1_sum);
         rsp_in.y1 = sat_coord(y1_sum);
         rsp_in.u0 = glyph.tl;
         rsp_in.v0 = glyph.tt;
         rsp_in.u1 = glyph.tr;
         rsp_in.v1 = glyph.tb;
         rsp_in.color = color_ff;
         rsp_in.is_glyph = 1'b1;
         rsp_in.lines = lines_ff;
         rsp_in.end_mark = 1'b0;
         pen_x_in = sat_coord(adv_sum);
      end
      if (cmd.emit_sum) begin
         rsp_valid_in = 1'b1;
         rsp_in = '0;
         rsp_in.color = color_ff;
         rsp_in.lines = lines_ff;
         rsp_in.end_mark = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= COORD_BITS'(4);
         color_ff <= 3'd7;
         lines_ff <= 16'd1;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
         color_ff <= color_in;
         lines_ff <= lines_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      rsp_ff <= rsp_in;
      if (cmd.tab_init) begin
         tw_ff <= TW_BITS'(glyph.adv * tab_count_ff);
         px_ff <= pen_x_ff[COORD_BITS-1] ? '0 : pen_x_ff[COORD_BITS-2:0];
      end
   end

   assign status.is_digit = (code_ff >= CH_ZERO) && (code_ff <= CH_SEVEN);
   assign status.is_newline = code_ff == CH_NEWLINE;
   assign status.is_tab = code_ff == CH_TAB;
   assign status.is_caret = code_ff == CH_CARET;
   assign status.last = last_ff;
   assign status.tw_zero = tw_ff == '0;
   assign status.div_done = cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

FILE: hw/rtl/tgql_ctrl.sv
// Controller of the glyph quad layout core: sequences each item through the
// datapath and tracks text start and a pending caret. Uses tgql_pkg.
module tgql_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_op,
   output logic req_ready,
   input  tgql_pkg::status_type status,
   output tgql_pkg::cmd_type cmd
);
   import tgql_pkg::*;

   state_type state_ff, state_in;
   logic fresh_ff, fresh_in;
   logic pend_ff, pend_in;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fresh_ff <= 1'b1;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fresh_ff <= fresh_in;
         pend_ff <= pend_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      fresh_in = fresh_ff;
      pend_in = pend_ff;
      cmd = '0;
      cmd.rd_sel = RD_ITEM;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  cmd.start = fresh_ff;
                  fresh_in = 1'b0;
                  pend_in = pend_ff && !fresh_ff;
                  state_in = ST_DISPATCH;
               end
            end
         end
         ST_DISPATCH: begin
            if (pend_ff) begin
               pend_in = 1'b0;
               if (status.is_digit) begin
                  cmd.set_color = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  cmd.rd_en = 1'b1;
                  cmd.rd_sel = RD_CARET;
                  state_in = ST_CARET_EMIT;
               end
            end else begin
               state_in = ST_CHAR;
            end
         end
         ST_CARET_EMIT: begin
            if (status.out_free) begin
               cmd.emit_quad = 1'b1;
               state_in = ST_CHAR;
            end
         end
         ST_CHAR: begin
            if (status.is_newline) begin
               cmd.newline = 1'b1;
               state_in = ST_FINISH;
            end else if (status.is_tab) begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = RD_SPACE;
               state_in = ST_TAB_MUL;
            end else if (status.is_caret && !status.last) begin
               pend_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.rd_en = 1'b1;
               state_in = ST_GLYPH_EMIT;
            end
         end
         ST_GLYPH_EMIT: begin
            if (status.out_free) begin
               cmd.emit_quad = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_TAB_MUL: begin
            cmd.tab_init = 1'b1;
            state_in = ST_TAB_DIV;
         end
         ST_TAB_DIV: begin
            if (status.tw_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.tab_step = 1'b1;
               if (status.div_done) state_in = ST_TAB_APPLY;
            end
         end
         ST_TAB_APPLY: begin
            cmd.tab_apply = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit_sum = 1'b1;
               fresh_in = 1'b1;
               pend_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

FILE: hw/rtl/text_glyph_quad_layout_core.sv
// Glyph quad layout core: top level joining controller and datapath.
// Depends on tgql_pkg, tgql_ctrl and tgql_datapath.
//
// Lays out a character stream into glyph quads from a 256-entry glyph table.
// A table write (op 0) gives no result. A layout item (op 1) is worked on
// alone. A color digit after a waiting caret sets the color and the caret is
// not drawn; any other item draws the pending caret first. A newline moves the
// pen down a line; a caret that is not the last item waits. Quads and summaries
// wait until the output register is free. A tab reads the space entry and
// multiplies, then runs a restoring divider one bit per cycle and moves the pen
// to the next tab stop, or leaves it when the tab width is zero. The last item
// of a text adds a summary transaction with end_mark set, in the item's final
// cycle. Results sit in an output register, so one result can wait while the
// core finishes the item. Configuration registers (0 line height, 1 descender,
// 2 tab count) are written through the csr port, always ready; write them only
// while the core is idle. Reading a table entry never written gives undefined
// quad and texel fields.
module text_glyph_quad_layout_core (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_op,
   input  logic [7:0] req_char_code,
   input  logic req_last,
   input  logic [7:0] req_advance,
   input  logic signed [7:0] req_offset_x,
   input  logic signed [7:0] req_baseline,
   input  logic [7:0] req_glyph_w,
   input  logic [7:0] req_glyph_h,
   input  logic [11:0] req_tex_left,
   input  logic [11:0] req_tex_top,
   input  logic [11:0] req_tex_right,
   input  logic [11:0] req_tex_bottom,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [15:0] rsp_quad_x0,
   output logic signed [15:0] rsp_quad_y0,
   output logic signed [15:0] rsp_quad_x1,
   output logic signed [15:0] rsp_quad_y1,
   output logic [11:0] rsp_tex_u0,
   output logic [11:0] rsp_tex_v0,
   output logic [11:0] rsp_tex_u1,
   output logic [11:0] rsp_tex_v1,
   output logic [2:0] rsp_color_index,
   output logic rsp_is_glyph,
   output logic [15:0] rsp_line_total,
   output logic rsp_end_mark
);
   import tgql_pkg::*;

   cmd_type cmd;
   status_type status;
   glyph_type req_glyph;
   result_type rsp_data;

   // configuration writes land at once
   assign csr_ready = 1'b1;

   // pack the table write payload
   assign req_glyph = '{adv: req_advance, offx: req_offset_x, base: req_baseline,
                        w: req_glyph_w, h: req_glyph_h, tl: req_tex_left,
                        tt: req_tex_top, tr: req_tex_right, tb: req_tex_bottom};

   tgql_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_op(req_op), .req_ready(req_ready),
      .status(status), .cmd(cmd)
   );

   tgql_datapath u_dp (
      .clock(clock), .reset(reset),
      .cmd(cmd), .status(status),
      .csr_we(csr_valid && csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .req_char_code(req_char_code), .req_last(req_last), .req_glyph(req_glyph),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // unpack the result register onto the ports
   assign rsp_quad_x0 = rsp_data.x0;
   assign rsp_quad_y0 = rsp_data.y0;
   assign rsp_quad_x1 = rsp_data.x1;
   assign rsp_quad_y1 = rsp_data.y1;
   assign rsp_tex_u0 = rsp_data.u0;
   assign rsp_tex_v0 = rsp_data.v0;
   assign rsp_tex_u1 = rsp_data.u1;
   assign rsp_tex_v1 = rsp_data.v1;
   assign rsp_color_index = rsp_data.color;
   assign rsp_is_glyph = rsp_data.is_glyph;
   assign rsp_line_total = rsp_data.lines;
   assign rsp_end_mark = rsp_data.end_mark;
endmodule

FILE: hw/rtl/tgql_checker.sv
// Port checker for the glyph quad layout core, bound to the top level.
// Depends on text_glyph_quad_layout_core.
module tgql_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [15:0] rsp_quad_x0,
   input logic [11:0] rsp_tex_u0,
   input logic rsp_is_glyph,
   input logic [15:0] rsp_line_total,
   input logic rsp_end_mark
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_glyph != rsp_end_mark))
      else $error("result is neither quad nor summary");
   a_sum_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_mark |-> (rsp_quad_x0 == 16'sd0) && (rsp_tex_u0 == 12'd0))
      else $error("summary carries quad data");
   a_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_total != 16'd0)
      else $error("line count zero");
endmodule

bind text_glyph_quad_layout_core tgql_checker u_tgql_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_quad_x0(rsp_quad_x0), .rsp_tex_u0(rsp_tex_u0), .rsp_is_glyph(rsp_is_glyph),
   .rsp_line_total(rsp_line_total), .rsp_end_mark(rsp_end_mark)
);
